// ----- design/vgqm_pkg.sv -----
// Shared types and constants of the voxel greedy quad mesher.
package vgqm_pkg;

  localparam int CW = 7;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_FETCH = 2'd2,
    OP_NONE  = 2'd3
  } vgqm_op_t;

  typedef struct packed {
    logic clear;
    logic wr;
  } vgqm_mark_ctl_t;

endpackage

// ----- design/vgqm_void_mem.sv -----
// One-bit void flag store with one write port and two registered read ports.
module vgqm_void_mem #(
  parameter int AW = 15
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic          rd_data_a,
  output logic          rd_data_b
);

  logic mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ----- design/vgqm_mark_mem.sv -----
// Consumed-face mark store with a clearing sweep after reset and on request.
module vgqm_mark_mem
  import vgqm_pkg::*;
#(
  parameter int AW = 14
) (
  input  logic           clk,
  input  logic           rst_n,
  input  vgqm_mark_ctl_t ctl,
  input  logic [AW-1:0]  wr_addr,
  input  logic [AW-1:0]  rd_addr,
  output logic           rd_data,
  output logic           busy
);

  logic          mem [2**AW];
  logic          busy_r;
  logic [AW-1:0] clr_cnt_r;

  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (ctl.clear) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == '1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_cnt_r] <= 1'b0;
    end else if (ctl.wr) begin
      mem[wr_addr] <= 1'b1;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/voxel_greedy_quad_mesher.sv -----
// Voxel chunk greedy mesher: void flag store, face marks and scan sequencer.
// Voxel write, start and no-op transactions are accepted in IDLE; start then sweeps the mark
// memory (2^(mark address bits) entries, 16384 at 16^3) before the next transaction.
// A fetch scans voxels and probes faces through the registered read ports, marks the
// faces of the quad found and emits one result, or a done result when the scan ends.
// Reset (rst_n, synchronous) clears control state and starts the mark sweep.
module voxel_greedy_quad_mesher
  import vgqm_pkg::*;
#(
  parameter int SIZE_X = 16,
  parameter int SIZE_Y = 16,
  parameter int SIZE_Z = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,     // void_id
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // vox_x, vox_y, vox_z, voxel_id, zero pad
  input  logic [1:0]  in_tuser,     // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,    // quad_axis, corner_x/y/z, extent_first/second,
                                    // first_vertex, zero pad
  output logic [0:0]  out_tuser     // done_res
);

  localparam int VXB = $clog2(SIZE_X + 1);
  localparam int VYB = $clog2(SIZE_Y + 1);
  localparam int VZB = $clog2(SIZE_Z + 1);
  localparam int CXB = $clog2(SIZE_X);
  localparam int CYB = $clog2(SIZE_Y);
  localparam int CZB = $clog2(SIZE_Z);
  localparam int VAW = VXB + VYB + VZB;
  localparam int MAW = 2 + CXB + CYB + CZB;
  localparam logic [CW-1:0] SZ_X = CW'(SIZE_X);
  localparam logic [CW-1:0] SZ_Y = CW'(SIZE_Y);
  localparam logic [CW-1:0] SZ_Z = CW'(SIZE_Z);

  typedef enum logic [3:0] {
    IDLE, SCAN_RD, SCAN_EV, F_RD, F_EV, S_INIT, S_RD, S_EV, MARK, EMIT
  } state_t;

  state_t          st_r;
  logic [15:0]     void_id_r;
  logic [1:0]      cur_a_r;
  logic [CW-1:0]   cur_r [3];
  logic [1:0]      ax_r;
  logic [CW-1:0]   c_r [3];
  logic [CW-1:0]   p_r [3];
  logic [CW-1:0]   fd_r, sd_r, k_r, fi_r, si_r;
  logic [13:0]     cnt_r;
  logic            done_r;
  logic            out_valid_r;
  logic [47:0]     out_data_r;
  logic            out_done_r;

  logic [1:0]      pa, fa, sa;
  logic [CW-1:0]   pr [3];
  logic [CW-1:0]   nb [3];
  logic [CW-1:0]   mp [3];
  logic [CW-1:0]   fsize, ssize;
  logic            v0, v1, mk, open_face, mark_busy;
  logic [CW-1:0]   in_x, in_y, in_z;
  logic            in_fire, in_range;
  vgqm_mark_ctl_t  mctl;
  logic [VAW-1:0]  v_wr_addr, v_rd_a, v_rd_b;
  logic [MAW-1:0]  m_wr_addr, m_rd_addr;
  logic [CW-1:0]   corner [3];

  function automatic logic [CW-1:0] size_of(input logic [1:0] k);
    logic [CW-1:0] r;
    unique case (k)
      2'd0:    r = SZ_X;
      2'd1:    r = SZ_Y;
      default: r = SZ_Z;
    endcase
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_tready = (st_r == IDLE) && !mark_busy;
  assign in_fire   = in_tvalid && in_tready;
  assign in_x = CW'(in_tdata[4:0]);
  assign in_y = CW'(in_tdata[9:5]);
  assign in_z = CW'(in_tdata[14:10]);
  assign in_range = (in_x <= SZ_X) && (in_y <= SZ_Y) && (in_z <= SZ_Z);

  assign pa = (st_r == SCAN_RD) ? cur_a_r : ax_r;
  assign fa = (ax_r == 2'd2) ? 2'd0 : ((ax_r == 2'd0) ? 2'd1 : 2'd2);
  assign sa = (ax_r == 2'd1) ? 2'd0 : ((ax_r == 2'd2) ? 2'd1 : 2'd2);
  assign fsize = size_of(fa);
  assign ssize = size_of(sa);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr[i]     = (st_r == SCAN_RD) ? cur_r[i] : p_r[i];
      nb[i]     = pr[i] + ((pa == 2'(i)) ? CW'(1) : CW'(0));
      mp[i]     = c_r[i] + ((fa == 2'(i)) ? fi_r : CW'(0)) + ((sa == 2'(i)) ? si_r : CW'(0));
      corner[i] = c_r[i] + ((ax_r == 2'(i)) ? CW'(1) : CW'(0));
    end
  end

  assign v_wr_addr = {in_z[VZB-1:0], in_y[VYB-1:0], in_x[VXB-1:0]};
  assign v_rd_a    = {pr[2][VZB-1:0], pr[1][VYB-1:0], pr[0][VXB-1:0]};
  assign v_rd_b    = {nb[2][VZB-1:0], nb[1][VYB-1:0], nb[0][VXB-1:0]};
  assign m_rd_addr = {pa, pr[2][CZB-1:0], pr[1][CYB-1:0], pr[0][CXB-1:0]};
  assign m_wr_addr = {ax_r, mp[2][CZB-1:0], mp[1][CYB-1:0], mp[0][CXB-1:0]};

  assign mctl.clear = in_fire && (in_tuser == OP_START);
  assign mctl.wr    = (st_r == MARK);

  assign open_face = !mk && (v0 != v1);

  vgqm_void_mem #(.AW(VAW)) u_void (
    .clk       (clk),
    .wr_en     (in_fire && (in_tuser == OP_WRITE) && in_range),
    .wr_addr   (v_wr_addr),
    .wr_data   (in_tdata[30:15] == void_id_r),
    .rd_addr_a (v_rd_a),
    .rd_addr_b (v_rd_b),
    .rd_data_a (v0),
    .rd_data_b (v1)
  );

  vgqm_mark_mem #(.AW(MAW)) u_mark (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mctl),
    .wr_addr (m_wr_addr),
    .rd_addr (m_rd_addr),
    .rd_data (mk),
    .busy    (mark_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= IDLE;
      void_id_r   <= '0;
      cur_a_r     <= '0;
      cur_r       <= '{default: '0};
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        void_id_r <= cfg_data;
      end
      if ((st_r == EMIT) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        IDLE: begin
          if (in_fire) begin
            unique case (in_tuser)
              OP_START: begin
                cur_a_r <= '0;
                cur_r   <= '{default: '0};
                cnt_r   <= '0;
              end
              OP_FETCH: st_r <= SCAN_RD;
              default: ;
            endcase
          end
        end
        SCAN_RD: begin
          if (cur_a_r == 2'd3) begin
            done_r <= 1'b1;
            st_r   <= EMIT;
          end else begin
            ax_r <= cur_a_r;
            c_r  <= cur_r;
            p_r  <= cur_r;
            st_r <= SCAN_EV;
            if (cur_r[0] == SZ_X - 1'b1) begin
              cur_r[0] <= '0;
              if (cur_r[1] == SZ_Y - 1'b1) begin
                cur_r[1] <= '0;
                if (cur_r[2] == SZ_Z - 1'b1) begin
                  cur_r[2] <= '0;
                  cur_a_r  <= cur_a_r + 1'b1;
                end else begin
                  cur_r[2] <= cur_r[2] + 1'b1;
                end
              end else begin
                cur_r[1] <= cur_r[1] + 1'b1;
              end
            end else begin
              cur_r[0] <= cur_r[0] + 1'b1;
            end
          end
        end
        SCAN_EV: begin
          fd_r <= '0;
          st_r <= open_face ? F_RD : SCAN_RD;
        end
        F_RD: begin
          if (p_r[fa] == fsize) begin
            fi_r <= '0;
            sd_r <= ssize;
            st_r <= S_INIT;
          end else begin
            st_r <= F_EV;
          end
        end
        F_EV: begin
          if (open_face) begin
            fd_r     <= fd_r + 1'b1;
            p_r[fa]  <= p_r[fa] + 1'b1;
            st_r     <= F_RD;
          end else begin
            fi_r <= '0;
            sd_r <= ssize;
            st_r <= S_INIT;
          end
        end
        S_INIT: begin
          if (fi_r == fd_r) begin
            fi_r <= '0;
            si_r <= '0;
            st_r <= MARK;
          end else begin
            for (int i = 0; i < 3; i++) begin
              p_r[i] <= (fa == 2'(i)) ? c_r[i] + fi_r : c_r[i];
            end
            k_r     <= '0;
            st_r    <= S_RD;
          end
        end
        S_RD: begin
          if (p_r[sa] == ssize) begin
            if (k_r < sd_r) sd_r <= k_r;
            fi_r <= fi_r + 1'b1;
            st_r <= S_INIT;
          end else begin
            st_r <= S_EV;
          end
        end
        S_EV: begin
          if (open_face) begin
            k_r     <= k_r + 1'b1;
            p_r[sa] <= p_r[sa] + 1'b1;
            st_r    <= S_RD;
          end else begin
            if (k_r < sd_r) sd_r <= k_r;
            fi_r <= fi_r + 1'b1;
            st_r <= S_INIT;
          end
        end
        MARK: begin
          if (si_r == sd_r - 1'b1) begin
            si_r <= '0;
            fi_r <= fi_r + 1'b1;
            if (fi_r == fd_r - 1'b1) begin
              done_r <= 1'b0;
              st_r   <= EMIT;
            end
          end else begin
            si_r <= si_r + 1'b1;
          end
        end
        EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_done_r  <= done_r;
            if (done_r) begin
              out_data_r <= '0;
            end else begin
              out_data_r <= {5'd0, cnt_r, 2'b00, sd_r[4:0], fd_r[4:0],
                             corner[2][4:0], corner[1][4:0], corner[0][4:0], ax_r};
              cnt_r <= cnt_r + 1'b1;
            end
            st_r <= IDLE;
          end
        end
        default: st_r <= IDLE;
      endcase
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_done_r;

`ifndef NO_ASSERTIONS
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("done result carries nonzero fields");

  a_mark_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mctl.wr |-> !mark_busy)
    else $error("face marked during clearing sweep");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser == OP_START |=> mark_busy && cnt_r == '0)
    else $error("start did not launch clearing sweep");

  a_quad_extent: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == MARK |-> fd_r != '0 && sd_r != '0)
    else $error("empty quad reached marking");
`endif

endmodule
